// ===== rtl/pl_pkg.sv =====
// pl_pkg: shared types and constants of the positional list engine
// no dependencies; imported by the interfaces, the cell and the top level
package pl_pkg;

  localparam int DEPTH     = 64;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 10;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = 7;
  // compare width wide enough for both a position and a count
  localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [1:0] {
    KIND_INSERT    = 2'd0,
    KIND_ERASE     = 2'd1,
    KIND_OVERWRITE = 2'd2,
    KIND_READ      = 2'd3
  } pl_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } pl_status_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic                     upd_en;
    pl_kind_t                 kind;
    logic [CMP_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
  } pl_bcast_t;

endpackage

// ===== rtl/pl_if.sv =====
// pl_req_if and pl_rsp_if: valid/ready channels of the positional list engine
// depends on pl_pkg for field widths
interface pl_req_if;
  import pl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;
  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface pl_rsp_if;
  import pl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [1:0]               status;
  logic [OUT_CNT_W-1:0]     count;
  modport source (output valid, read_value, status, count, input ready);
  modport sink   (input valid, read_value, status, count, output ready);
endinterface

// ===== rtl/pl_cell.sv =====
// pl_cell: one list slot, shifts with its neighbors on insert and erase
// depends on pl_pkg for the broadcast struct and widths
module pl_cell
  import pl_pkg::*;
(
  input  logic                     clk,
  input  logic [CMP_W-1:0]         idx,
  input  pl_bcast_t                bc,
  input  logic signed [DATA_W-1:0] left_in,
  input  logic signed [DATA_W-1:0] right_in,
  output logic signed [DATA_W-1:0] data_out,
  output logic signed [DATA_W-1:0] tap_out
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     hit;
  logic                     above;

  assign hit   = (idx == bc.pos);
  assign above = (idx > bc.pos);

  always_comb begin
    data_nxt = data_r;
    if (bc.upd_en) begin
      unique case (bc.kind)
        KIND_INSERT: begin
          if (above) data_nxt = left_in;
          else if (hit) data_nxt = bc.val;
        end
        KIND_ERASE: begin
          if (above || hit) data_nxt = right_in;
        end
        KIND_OVERWRITE: begin
          if (hit) data_nxt = bc.val;
        end
        KIND_READ: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;
  // masked tap so the top can or-reduce the row for a read
  assign tap_out  = hit ? data_r : '0;

endmodule

// ===== rtl/positional_list_engine_core.sv =====
// positional_list_engine_core: ordered list held in a shifting row of cells
// depends on pl_pkg, pl_req_if, pl_rsp_if and pl_cell
//
//   channel  | dir | fields                         | handshake
//   in_ch    | in  | kind, position, value          | valid/ready
//   out_ch   | out | read_value, status, count      | valid/ready
//
// one request per cycle unless a waiting result stalls input; the cells update at the edge that accepts it
// the result is registered and shows the cycle after acceptance
// a waiting result stalls input only if out_ch.ready is low
// synchronous active-low reset clears the count and output valid; cell data is not reset
module positional_list_engine_core
  import pl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  pl_req_if.sink   in_ch,
  pl_rsp_if.source out_ch
);

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] rd_r, rd_nxt;
  pl_status_t               st_r, st_nxt;
  logic [OUT_CNT_W-1:0]     ocnt_r, ocnt_nxt;

  logic                     acc;
  logic [CMP_W-1:0]         pos_ext, cnt_ext;
  logic                     full, in_range;
  pl_kind_t                 kind;
  pl_bcast_t                bc;
  logic signed [DATA_W-1:0] data_q [DEPTH];
  logic signed [DATA_W-1:0] tap_q  [DEPTH];
  logic signed [DATA_W-1:0] tap_or;
  logic [31:0]              cnt_wide;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign kind        = pl_kind_t'(in_ch.kind);
  assign pos_ext     = CMP_W'(in_ch.position);
  assign cnt_ext     = CMP_W'(count_r);
  assign full        = (cnt_ext == CMP_W'(DEPTH));
  assign in_range    = (pos_ext < cnt_ext);

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) tap_or = tap_or | tap_q[i];
  end

  always_comb begin
    bc.upd_en = 1'b0;
    bc.kind   = kind;
    bc.pos    = pos_ext;
    bc.val    = in_ch.value;
    count_nxt = count_r;
    rd_nxt    = '0;
    st_nxt    = ST_OK;
    unique case (kind)
      KIND_INSERT: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          bc.upd_en = acc;
          // past the end means append
          if (pos_ext > cnt_ext) bc.pos = cnt_ext;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_ERASE: begin
        if (!in_range) begin
          st_nxt = ST_RANGE;
        end else begin
          bc.upd_en = acc;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      KIND_OVERWRITE: begin
        if (!in_range) st_nxt = ST_RANGE;
        else bc.upd_en = acc;
      end
      KIND_READ: begin
        if (!in_range) st_nxt = ST_RANGE;
        else rd_nxt = tap_or;
      end
      default: ;
    endcase
  end

  assign cnt_wide      = 32'(count_nxt);
  assign ocnt_nxt      = cnt_wide[OUT_CNT_W-1:0];
  assign out_valid_nxt = acc ? 1'b1 : (out_valid_r && !out_ch.ready);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = data_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = data_q[g];
    end else begin : g_mid_r
      assign right_d = data_q[g+1];
    end
    pl_cell u_cell (
      .clk      (clk),
      .idx      (CMP_W'(g)),
      .bc       (bc),
      .left_in  (left_d),
      .right_in (right_d),
      .data_out (data_q[g]),
      .tap_out  (tap_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r   <= rd_nxt;
      st_r   <= st_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = rd_r;
  assign out_ch.status     = st_r;
  assign out_ch.count      = ocnt_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind == KIND_INSERT && !full |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    acc && st_nxt == ST_FULL |-> CMP_W'(count_r) == CMP_W'(DEPTH))
    else $error("full status with room left");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && st_r != ST_OK |-> rd_r == '0)
    else $error("read value on a failed request");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted request gave no result");

endmodule
